// File: design/position_velocity_kalman_filter_top_assert.svh
// Assertion macros for the position/velocity Kalman filter top level.
`ifndef POSITION_VELOCITY_KALMAN_FILTER_TOP_ASSERT_SVH
`define POSITION_VELOCITY_KALMAN_FILTER_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is active
`define PVKF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define PVKF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/pvkf_pkg.sv
// Shared types, constants and helpers for the position/velocity Kalman filter.
`default_nettype none
package pvkf_pkg;

	localparam int FRAC_BITS = 20;
	localparam int Q_ONE_INT = 1 << FRAC_BITS;
	localparam logic signed [31:0] Q_ONE = 32'(Q_ONE_INT);
	localparam logic signed [31:0] DEADBAND = 32'((3 * Q_ONE_INT + 5) / 10);

	// Noise register reset values
	localparam logic [30:0] QX_RESET = 31'((Q_ONE_INT + 5000) / 10000);
	localparam logic [30:0] QV_RESET = 31'((Q_ONE_INT + 5) / 10);
	localparam logic [30:0] RV_RESET = 31'(Q_ONE_INT / 2);
	localparam logic [30:0] RX_RESET = 31'((Q_ONE_INT + 50) / 100);

	// Configuration register indexes
	localparam logic [1:0] CFG_POS_PROC = 2'd0;
	localparam logic [1:0] CFG_VEL_PROC = 2'd1;
	localparam logic [1:0] CFG_VEL_MEAS = 2'd2;
	localparam logic [1:0] CFG_POS_MEAS = 2'd3;

	// Action codes
	localparam logic [1:0] ACT_RESET   = 2'd0;
	localparam logic [1:0] ACT_PREDICT = 2'd1;
	localparam logic [1:0] ACT_VEL_UPD = 2'd2;
	localparam logic [1:0] ACT_POS_UPD = 2'd3;

	localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] accel;
		logic [20:0]        step_time;
		logic signed [31:0] measurement;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic signed [31:0] gain;
		logic               skipped;
	} out_item_t;

	// Divider request and response
	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [31:0] quo;
	} div_rsp_t;

	// Saturate a wide signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > S32_MAX) return 32'sh7FFFFFFF;
		else if (v < S32_MIN) return 32'sh80000000;
		else return v[31:0];
	endfunction

endpackage
`default_nettype wire

// File: design/pvkf_div.sv
// Serial restoring divider: sat((num * 2^FRAC_BITS) / den), den > 0, one bit per cycle.
`default_nettype none
module pvkf_div
	import pvkf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int W = 32 + FRAC_BITS;
	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     dvd_q;
	logic [31:0]      rem_q;
	logic [31:0]      den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic signed [31:0] quo_q;

	logic [31:0] num_mag;
	logic [31:0] rem_sh;
	logic        take;
	logic [W-1:0] dvd_nx;

	assign num_mag = req.num[31] ? 32'(-req.num) : 32'(req.num);

	// Shift in next dividend bit and trial subtract
	assign rem_sh = {rem_q[30:0], dvd_q[W-1]};
	assign take   = (rem_sh >= den_q);
	assign dvd_nx = {dvd_q[W-2:0], take};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
				dvd_q  <= {num_mag, {FRAC_BITS{1'b0}}};
				rem_q  <= '0;
				den_q  <= req.den;
				neg_q  <= req.num[31];
			end else if (busy_q) begin
				dvd_q <= dvd_nx;
				rem_q <= take ? rem_sh - den_q : rem_sh;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					// Apply sign and saturate the magnitude
					if (!neg_q) begin
						quo_q <= sat32(66'($signed({1'b0, dvd_nx})));
					end else begin
						quo_q <= sat32(-66'($signed({1'b0, dvd_nx})));
					end
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
`default_nettype wire

// File: design/position_velocity_kalman_filter_top.sv
// Top level of the two-state position/velocity Kalman filter.
// Usage:
//   in_valid/in_ready/in_data carry one transaction per step: an action
//   (reset, predict, velocity update, position update) with its operands.
//   out_valid/out_ready/out_data return exactly one result per step:
//   position, velocity, gain and the skipped flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the four noise registers;
//   cfg_ready is always high, write only while the filter is idle.
// Sequencing:
//   All multiplications run on one shared 33x33 multiplier; each micro step is a
//   multiply state, then a round/saturate/accumulate state. The reset action
//   uses no steps. Predict: 9 steps. Updates: 8 steps plus two serial divisions
//   for the gains; a skipped update stops after the first step.
//   in_ready is high only while no step is in progress.
// Reset: arst_n clears the estimates, sets the covariance to identity and
//   reloads the noise registers with their defaults.
// Stall: a finished result waits in the output register; the next result holds
//   the sequencer in its final state until out_ready takes the waiting one.
`default_nettype none
module position_velocity_kalman_filter_top
	import pvkf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_item_t       out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [30:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_CHK, ST_DIV1, ST_DIV2, ST_FIN
	} state_t;

	typedef enum logic [4:0] {
		SRC_ZERO, SRC_ONE, SRC_DT, SRC_DT2X, SRC_DT2, SRC_POS, SRC_VEL, SRC_ACC,
		SRC_PXX, SRC_PXV, SRC_PVX, SRC_PVV, SRC_KX, SRC_KV, SRC_Y, SRC_Z,
		SRC_QX, SRC_QV, SRC_RV, SRC_RX
	} src_t;

	typedef enum logic [3:0] {
		DST_DT2, DST_POS, DST_VEL, DST_PXX, DST_PXV, DST_PVX, DST_PVV, DST_S, DST_Y
	} dst_t;

	typedef struct packed {
		src_t a;
		src_t b;
		src_t base;
		dst_t dst;
		logic sub;
		logic last;
	} step_t;

	state_t state_q;
	logic [3:0] idx_q;
	in_item_t inq_q;
	logic [30:0] qx_q, qv_q, rv_q, rx_q;
	logic signed [31:0] pos_q, vel_q, pxx_q, pxv_q, pvx_q, pvv_q;
	logic signed [31:0] dt2_q, s_q, y_q, kx_q, kv_q;
	logic signed [65:0] prod_s1;
	logic out_valid_q;
	out_item_t out_q;
	logic skip_q;

	step_t step;
	logic signed [32:0] opa, opb, opbase;
	logic signed [31:0] acc_eff;
	logic signed [65:0] rnd;
	logic signed [31:0] mres;
	logic signed [33:0] sum;
	logic signed [31:0] wres;
	logic is_vel;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign is_vel = (inq_q.action == ACT_VEL_UPD);

	// Deadbanded acceleration
	assign acc_eff = (inq_q.accel > -DEADBAND && inq_q.accel < DEADBAND) ? '0 : inq_q.accel;

	// Operand select for the shared multiplier and accumulator
	function automatic logic signed [32:0] pick(input src_t s);
		case (s)
			SRC_ZERO: return '0;
			SRC_ONE:  return 33'(Q_ONE);
			SRC_DT:   return {12'd0, inq_q.step_time};
			SRC_DT2X: return {11'd0, inq_q.step_time, 1'b0};
			SRC_DT2:  return {dt2_q[31], dt2_q};
			SRC_POS:  return {pos_q[31], pos_q};
			SRC_VEL:  return {vel_q[31], vel_q};
			SRC_ACC:  return {acc_eff[31], acc_eff};
			SRC_PXX:  return {pxx_q[31], pxx_q};
			SRC_PXV:  return {pxv_q[31], pxv_q};
			SRC_PVX:  return {pvx_q[31], pvx_q};
			SRC_PVV:  return {pvv_q[31], pvv_q};
			SRC_KX:   return {kx_q[31], kx_q};
			SRC_KV:   return {kv_q[31], kv_q};
			SRC_Y:    return {y_q[31], y_q};
			SRC_Z:    return {inq_q.measurement[31], inq_q.measurement};
			SRC_QX:   return {2'b00, qx_q};
			SRC_QV:   return {2'b00, qv_q};
			SRC_RV:   return {2'b00, rv_q};
			SRC_RX:   return {2'b00, rx_q};
			default:  return '0;
		endcase
	endfunction

	// Micro program: dst = sat(base +/- qmul(a, b))
	always_comb begin
		step = '{a: SRC_ZERO, b: SRC_ZERO, base: SRC_ZERO, dst: DST_Y, sub: 1'b0, last: 1'b1};
		unique case (inq_q.action)
			ACT_PREDICT: begin
				unique case (idx_q)
					4'd0: step = '{SRC_DT, SRC_DT, SRC_ZERO, DST_DT2, 1'b0, 1'b0};
					4'd1: step = '{SRC_VEL, SRC_DT, SRC_POS, DST_POS, 1'b0, 1'b0};
					4'd2: step = '{SRC_ACC, SRC_DT, SRC_VEL, DST_VEL, 1'b0, 1'b0};
					4'd3: step = '{SRC_DT2X, SRC_PXV, SRC_PXX, DST_PXX, 1'b0, 1'b0};
					4'd4: step = '{SRC_DT2, SRC_PVV, SRC_PXX, DST_PXX, 1'b0, 1'b0};
					4'd5: step = '{SRC_QX, SRC_ONE, SRC_PXX, DST_PXX, 1'b0, 1'b0};
					4'd6: step = '{SRC_DT, SRC_PVV, SRC_PXV, DST_PXV, 1'b0, 1'b0};
					4'd7: step = '{SRC_PXV, SRC_ONE, SRC_ZERO, DST_PVX, 1'b0, 1'b0};
					default: step = '{SRC_QV, SRC_ONE, SRC_PVV, DST_PVV, 1'b0, 1'b1};
				endcase
			end
			ACT_VEL_UPD: begin
				unique case (idx_q)
					4'd0: step = '{SRC_PVV, SRC_ONE, SRC_RV, DST_S, 1'b0, 1'b0};
					4'd1: step = '{SRC_VEL, SRC_ONE, SRC_Z, DST_Y, 1'b1, 1'b0};
					4'd2: step = '{SRC_KX, SRC_Y, SRC_POS, DST_POS, 1'b0, 1'b0};
					4'd3: step = '{SRC_KV, SRC_Y, SRC_VEL, DST_VEL, 1'b0, 1'b0};
					4'd4: step = '{SRC_KX, SRC_PVX, SRC_PXX, DST_PXX, 1'b1, 1'b0};
					4'd5: step = '{SRC_KX, SRC_PVV, SRC_PXV, DST_PXV, 1'b1, 1'b0};
					4'd6: step = '{SRC_KV, SRC_PVX, SRC_PVX, DST_PVX, 1'b1, 1'b0};
					default: step = '{SRC_KV, SRC_PVV, SRC_PVV, DST_PVV, 1'b1, 1'b1};
				endcase
			end
			ACT_POS_UPD: begin
				unique case (idx_q)
					4'd0: step = '{SRC_PXX, SRC_ONE, SRC_RX, DST_S, 1'b0, 1'b0};
					4'd1: step = '{SRC_POS, SRC_ONE, SRC_Z, DST_Y, 1'b1, 1'b0};
					4'd2: step = '{SRC_KX, SRC_Y, SRC_POS, DST_POS, 1'b0, 1'b0};
					4'd3: step = '{SRC_KV, SRC_Y, SRC_VEL, DST_VEL, 1'b0, 1'b0};
					4'd4: step = '{SRC_KV, SRC_PXX, SRC_PVX, DST_PVX, 1'b1, 1'b0};
					4'd5: step = '{SRC_KV, SRC_PXV, SRC_PVV, DST_PVV, 1'b1, 1'b0};
					4'd6: step = '{SRC_KX, SRC_PXX, SRC_PXX, DST_PXX, 1'b1, 1'b0};
					default: step = '{SRC_PVX, SRC_ONE, SRC_ZERO, DST_PXV, 1'b0, 1'b1};
				endcase
			end
			default: ;
		endcase
	end

	// Operands follow every register that the selector reads
	always_comb begin
		opa    = pick(step.a);
		opb    = pick(step.b);
		opbase = pick(step.base);
	end

	// Round to nearest, saturate, then accumulate with saturation
	assign rnd  = (prod_s1 + 66'(Q_ONE_INT / 2)) >>> FRAC_BITS;
	assign mres = sat32(rnd);
	assign sum  = step.sub ? ({opbase[32], opbase} - 34'(mres)) : ({opbase[32], opbase} + 34'(mres));
	assign wres = sat32(66'(sum));

	// Divider requests: Kx first, then Kv
	always_comb begin
		div_req.start = 1'b0;
		div_req.den   = s_q;
		div_req.num   = is_vel ? pxv_q : pxx_q;
		if (state_q == ST_CHK && s_q > 0) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_DIV1 && div_rsp.done) begin
			div_req.start = 1'b1;
			div_req.num   = is_vel ? pvv_q : pvx_q;
		end
	end

	pvkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			skip_q      <= 1'b0;
			pos_q <= '0; vel_q <= '0;
			pxx_q <= Q_ONE; pxv_q <= '0; pvx_q <= '0; pvv_q <= Q_ONE;
			kx_q  <= '0; kv_q <= '0;
			qx_q <= QX_RESET; qv_q <= QV_RESET; rv_q <= RV_RESET; rx_q <= RX_RESET;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			// Configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_POS_PROC: qx_q <= cfg_data;
					CFG_VEL_PROC: qv_q <= cfg_data;
					CFG_VEL_MEAS: rv_q <= cfg_data;
					CFG_POS_MEAS: rx_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						inq_q  <= in_data;
						idx_q  <= '0;
						skip_q <= 1'b0;
						kx_q   <= '0;
						kv_q   <= '0;
						if (in_data.action == ACT_RESET) begin
							pos_q <= '0; vel_q <= '0;
							pxx_q <= Q_ONE; pxv_q <= '0; pvx_q <= '0; pvv_q <= Q_ONE;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_s1 <= opa * opb;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					unique case (step.dst)
						DST_DT2: dt2_q <= wres;
						DST_POS: pos_q <= wres;
						DST_VEL: vel_q <= wres;
						DST_PXX: pxx_q <= wres;
						DST_PXV: pxv_q <= wres;
						DST_PVX: pvx_q <= wres;
						DST_PVV: pvv_q <= wres;
						DST_S:   s_q   <= wres;
						DST_Y:   y_q   <= wres;
						default: ;
					endcase
					idx_q <= idx_q + 1'b1;
					if (step.last) state_q <= ST_FIN;
					else if (step.dst == DST_S) state_q <= ST_CHK;
					else state_q <= ST_MUL;
				end
				ST_CHK: begin
					if (s_q > 0) begin
						state_q <= ST_DIV1;
					end else begin
						skip_q  <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						kx_q    <= div_rsp.quo;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						kv_q    <= div_rsp.quo;
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q     <= 1'b1;
						out_q.position  <= pos_q;
						out_q.velocity  <= vel_q;
						out_q.skipped   <= skip_q;
						out_q.gain      <= skip_q ? '0 :
							(inq_q.action == ACT_VEL_UPD) ? kv_q :
							(inq_q.action == ACT_POS_UPD) ? kx_q : '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Assertions
	`include "position_velocity_kalman_filter_top_assert.svh"

	`PVKF_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "step accepted while busy")
	`PVKF_ASSERT(a_skip_no_gain, out_valid |-> !(out_data.skipped && out_data.gain != 0), "skip with gain")
	`PVKF_ASSERT(a_div_in_div, div_rsp.busy |-> (state_q == ST_DIV1 || state_q == ST_DIV2), "stray div")
	`PVKF_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "output valid in reset")

endmodule
`default_nettype wire

// File: tb/sv/position_velocity_kalman_filter_top_tb.sv
// Self-checking testbench for the position/velocity Kalman filter top level.
`default_nettype none
module position_velocity_kalman_filter_top_tb;
	import pvkf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1950;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;

	position_velocity_kalman_filter_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Filter copy used to predict each result
	longint est_pos, est_vel, p_xx, p_xv, p_vx, p_vv;
	longint noise_qx, noise_qv, noise_rv, noise_rx;
	out_item_t filter_results[$];
	int errors = 0;
	bit stim_done = 0;
	bit stall_en = 1;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		longint p;
		p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
		return clamp32(p >>> FRAC_BITS);
	endfunction

	function automatic longint fx_div(longint a, longint b);
		if (b <= 0) return 0;
		return clamp32((a * (64'sd1 <<< FRAC_BITS)) / b);
	endfunction

	function automatic void clear_filter();
		est_pos = 0;
		est_vel = 0;
		p_xx = Q_ONE;
		p_xv = 0;
		p_vx = 0;
		p_vv = Q_ONE;
	endfunction

	function automatic void write_noise(logic [1:0] idx, logic [30:0] val);
		case (idx)
			CFG_POS_PROC: noise_qx = val;
			CFG_VEL_PROC: noise_qv = val;
			CFG_VEL_MEAS: noise_rv = val;
			default: noise_rx = val;
		endcase
	endfunction

	// Advance the filter copy by one transaction and return its result
	function automatic out_item_t filter_step(in_item_t it);
		out_item_t r;
		longint a, dt, z, dt2, s, kx, kv, y, oxx, oxv, ovx, ovv;
		a = longint'(it.accel);
		dt = longint'({1'b0, it.step_time});
		z = longint'(it.measurement);
		r.gain = 0;
		r.skipped = 0;
		oxx = p_xx; oxv = p_xv; ovx = p_vx; ovv = p_vv;
		case (it.action)
			ACT_RESET: clear_filter();
			ACT_PREDICT: begin
				dt2 = fx_mul(dt, dt);
				if (a > -longint'(DEADBAND) && a < longint'(DEADBAND)) a = 0;
				est_pos = clamp32(est_pos + fx_mul(est_vel, dt));
				est_vel = clamp32(est_vel + fx_mul(a, dt));
				p_xx = clamp32(clamp32(clamp32(oxx + fx_mul(2 * dt, oxv))
					+ fx_mul(dt2, ovv)) + noise_qx);
				p_xv = clamp32(oxv + fx_mul(dt, ovv));
				p_vx = p_xv;
				p_vv = clamp32(ovv + noise_qv);
			end
			default: begin
				s = (it.action == ACT_VEL_UPD) ? clamp32(ovv + noise_rv)
					: clamp32(oxx + noise_rx);
				if (s <= 0) begin
					r.skipped = 1;
				end else if (it.action == ACT_VEL_UPD) begin
					kx = fx_div(oxv, s);
					kv = fx_div(ovv, s);
					y = clamp32(z - est_vel);
					est_pos = clamp32(est_pos + fx_mul(kx, y));
					est_vel = clamp32(est_vel + fx_mul(kv, y));
					p_xx = clamp32(oxx - fx_mul(kx, ovx));
					p_xv = clamp32(oxv - fx_mul(kx, ovv));
					p_vx = clamp32(ovx - fx_mul(kv, ovx));
					p_vv = clamp32(ovv - fx_mul(kv, ovv));
					r.gain = kv[31:0];
				end else begin
					kx = fx_div(oxx, s);
					kv = fx_div(ovx, s);
					y = clamp32(z - est_pos);
					est_pos = clamp32(est_pos + fx_mul(kx, y));
					est_vel = clamp32(est_vel + fx_mul(kv, y));
					p_xx = clamp32(oxx - fx_mul(kx, oxx));
					p_vx = clamp32(ovx - fx_mul(kv, oxx));
					p_vv = clamp32(ovv - fx_mul(kv, oxv));
					p_xv = p_vx;
					r.gain = kx[31:0];
				end
			end
		endcase
		r.position = est_pos[31:0];
		r.velocity = est_vel[31:0];
		return r;
	endfunction

	// Clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Limit
	initial begin
		#100ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: stall pattern, compare on accepted transaction
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (!stall_en) out_ready <= 1;
			else case ($urandom_range(0, 3))
				0: out_ready <= 0;
				1: out_ready <= ($urandom_range(0, 7) != 0);
				default: out_ready <= 1;
			endcase
		end
	end

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (filter_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $realtime, out_data);
			end else begin
				e = filter_results.pop_front();
				if (out_data.position !== e.position) begin
					errors++;
					$display("%0t: position exp %h got %h", $realtime, e.position,
						out_data.position);
				end
				if (out_data.velocity !== e.velocity) begin
					errors++;
					$display("%0t: velocity exp %h got %h", $realtime, e.velocity,
						out_data.velocity);
				end
				if (out_data.gain !== e.gain) begin
					errors++;
					$display("%0t: gain exp %h got %h", $realtime, e.gain, out_data.gain);
				end
				if (out_data.skipped !== e.skipped) begin
					errors++;
					$display("%0t: skipped exp %b got %b", $realtime, e.skipped,
						out_data.skipped);
				end
			end
		end
	end

	// Send one transaction; valid drops only for the gap between bursts
	int burst_left = 0;
	task automatic send_item(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		filter_results.push_back(filter_step(it));
		@(negedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [30:0] val);
		in_valid <= 0;
		while (filter_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		write_noise(idx, val);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic in_item_t make_item(logic [1:0] act, logic signed [31:0] a,
		logic [20:0] dt, logic signed [31:0] z);
		in_item_t it;
		it.action = act;
		it.accel = a;
		it.step_time = dt;
		it.measurement = z;
		return it;
	endfunction

	// Random accel near and far from the deadband
	function automatic logic signed [31:0] rand_accel();
		case ($urandom_range(0, 3))
			0: return $signed(DEADBAND) + $signed($urandom_range(0, 4)) - 2;
			1: return -$signed(DEADBAND) + $signed($urandom_range(0, 4)) - 2;
			2: return $urandom;
			default: return $signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_meas();
		if ($urandom_range(0, 5) == 0) return $urandom;
		return $signed($urandom_range(0, 64 << FRAC_BITS)) - (32 << FRAC_BITS);
	endfunction

	// Directed table: expected result typed in where obvious, else predicted
	typedef struct {
		in_item_t item;
		bit has_exp;
		out_item_t exp_res;
	} dir_row_t;

	initial begin
		dir_row_t rows[$];
		in_item_t it;
		out_item_t predicted;
		logic [30:0] cfg_sets[4][4];
		int k;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = CFG_POS_PROC;
		cfg_data = '0;
		arst_n = 0;
		clear_filter();
		noise_qx = QX_RESET; noise_qv = QV_RESET; noise_rv = RV_RESET; noise_rx = RX_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		rows.push_back('{make_item(ACT_RESET, 32'sh7FFFFFFF, 21'h1FFFFF, 32'sh80000000), 1,
			'{32'sd0, 32'sd0, 32'sd0, 1'b0}});
		rows.push_back('{make_item(ACT_PREDICT, DEADBAND - 1, 21'd1 << FRAC_BITS, 0), 1,
			'{32'sd0, 32'sd0, 32'sd0, 1'b0}});
		rows.push_back('{make_item(ACT_PREDICT, -DEADBAND + 1, 21'd1 << FRAC_BITS, 0), 1,
			'{32'sd0, 32'sd0, 32'sd0, 1'b0}});
		rows.push_back('{make_item(ACT_PREDICT, DEADBAND, 21'd1 << FRAC_BITS, 0), 0, '0});
		rows.push_back('{make_item(ACT_PREDICT, -DEADBAND, 21'd1 << (FRAC_BITS - 1), 0), 0, '0});
		rows.push_back('{make_item(ACT_VEL_UPD, 0, 0, 32'sh7FFFFFFF), 0, '0});
		rows.push_back('{make_item(ACT_POS_UPD, 0, 0, 32'sh80000000), 0, '0});
		rows.push_back('{make_item(ACT_PREDICT, 32'sh7FFFFFFF, 21'h1FFFFF, 0), 0, '0});
		rows.push_back('{make_item(ACT_PREDICT, 32'sh80000000, 21'h1FFFFF, 32'sh7FFFFFFF), 0, '0});
		rows.push_back('{make_item(ACT_PREDICT, 32'sh7FFFFFFF, 21'h1FFFFF, 0), 0, '0});
		rows.push_back('{make_item(ACT_POS_UPD, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF), 0, '0});
		rows.push_back('{make_item(ACT_VEL_UPD, 0, 0, 32'sh80000000), 0, '0});
		rows.push_back('{make_item(ACT_PREDICT, 0, 21'd0, 0), 0, '0});
		rows.push_back('{make_item(ACT_RESET, 0, 0, 0), 1, '{32'sd0, 32'sd0, 32'sd0, 1'b0}});
		foreach (rows[i]) begin
			predicted = filter_step(rows[i].item);
			est_pos = est_pos; // keep copy: roll back by re-running below
			if (rows[i].has_exp && predicted !== rows[i].exp_res) begin
				errors++;
				$display("%0t: row %0d exp %h got %h", $realtime, i, rows[i].exp_res,
					predicted);
			end
		end
		// Rewind the copy and drive the table for real
		clear_filter();
		foreach (rows[i]) send_item(rows[i].item);

		// Noise settings: defaults, zero, maximum (overflows S), mixed; the last phase uses random values
		cfg_sets[0] = '{QX_RESET, QV_RESET, RV_RESET, RX_RESET};
		cfg_sets[1] = '{31'd0, 31'd0, 31'd0, 31'd0};
		cfg_sets[2] = '{31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF};
		cfg_sets[3] = '{31'h2AAAAAAA, 31'h55555555, 31'd1, 31'd1 << FRAC_BITS};
		for (int ph = 0; ph < 6; ph++) begin
			stall_en = (ph != 2);
			k = (ph < 4) ? ph : (ph == 4 ? 2 : 0);
			for (int r = 0; r < 4; r++)
				write_cfg(r[1:0], (ph == 5) ? 31'($urandom) : cfg_sets[k][r]);
			send_item(make_item(ACT_RESET, $urandom, 21'($urandom), $urandom));
			for (int n = 0; n < N_RANDOM / 6; n++) begin
				case ($urandom_range(0, 19))
					0: it = make_item(ACT_RESET, $urandom, 21'($urandom), $urandom);
					1, 2, 3, 4, 5, 6, 7:
						it = make_item(ACT_PREDICT, rand_accel(),
							($urandom_range(0, 9) == 0) ? 21'($urandom)
							: 21'($urandom_range(0, 1 << FRAC_BITS)), $urandom);
					8, 9, 10, 11, 12, 13:
						it = make_item(ACT_VEL_UPD, $urandom, 21'($urandom), rand_meas());
					default:
						it = make_item(ACT_POS_UPD, $urandom, 21'($urandom), rand_meas());
				endcase
				send_item(it);
			end
		end
		in_valid <= 0;
		stim_done = 1;

		// Drain, then let the pipeline settle
		while (filter_results.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
